// ===== rtl/core/iqh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iqh_pkg
// Shared types, constants and helper functions of the IQ sample range
// histogram: sample and count widths, bin addressing, saturating increment.
// ----------------------------------------------------------------------------
package iqh_pkg;

  // Core widths: sample bits set the bin count, count bits the saturation.
  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_BITS  = 32;

  // Fixed widths of the sample and count ports.
  localparam int PORT_SAMPLE_W = 16;
  localparam int PORT_COUNT_W  = 32;

  localparam int NUM_BINS = 1 << SAMPLE_BITS;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [SAMPLE_BITS-1:0]        bin_addr_t;
  typedef logic [COUNT_BITS-1:0]         count_t;

  localparam sample_t   SAMPLE_MAXV = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t   SAMPLE_MINV = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam count_t    COUNT_MAX   = {COUNT_BITS{1'b1}};
  localparam bin_addr_t BIN_LAST    = {SAMPLE_BITS{1'b1}};

  // Item action codes.
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_READ   = 1'b1;

  // Channel codes.
  localparam logic CH_EVEN = 1'b0;
  localparam logic CH_ODD  = 1'b1;

  // Request from the accept stage to the bin store.
  typedef struct packed {
    logic      issue;
    logic      chan;
    bin_addr_t addr;
    logic      inc;
  } bin_req_t;

  // Channel extremes and totals after one item.
  typedef struct packed {
    sample_t even_low;
    sample_t even_high;
    sample_t odd_low;
    sample_t odd_high;
    count_t  even_total;
    count_t  odd_total;
  } track_state_t;

  // Low sample bits of a port value, sign-extended from the top sample bit.
  function automatic sample_t to_sample(logic [PORT_SAMPLE_W-1:0] raw);
    return sample_t'(raw[SAMPLE_BITS-1:0]);
  endfunction

  // Bin address: sample bits with the sign bit inverted.
  function automatic bin_addr_t bin_index(logic [PORT_SAMPLE_W-1:0] raw);
    return {~raw[SAMPLE_BITS-1], raw[SAMPLE_BITS-2:0]};
  endfunction

  // Increment that sticks at the all-ones count.
  function automatic count_t sat_inc(count_t v);
    return (v == COUNT_MAX) ? v : v + count_t'(1);
  endfunction

endpackage

// ===== rtl/core/iqh_bin_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iqh_bin_ram
// Simple dual-port synchronous RAM: one write port, one registered read
// port (read returns the old data on a same-address write).
// ----------------------------------------------------------------------------
module iqh_bin_ram #(
  parameter int ADDR_BITS = 16,
  parameter int DATA_BITS = 32
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [DATA_BITS-1:0] wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [DATA_BITS-1:0] rdata
);

  localparam int DEPTH = 1 << ADDR_BITS;

  logic [DATA_BITS-1:0] mem [0:DEPTH-1];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/iqh_bin_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iqh_bin_store
// Even and odd histogram memories: a read-modify-write of one bin per
// increment, last-write forwarding, and a clearing sweep after reset.
// ----------------------------------------------------------------------------
module iqh_bin_store (
  input  logic              clk,
  input  logic              rst_n,
  input  iqh_pkg::bin_req_t req,
  input  logic              adv,
  output logic              busy,
  output iqh_pkg::count_t   cur_count
);

  // Clearing sweep state.
  logic               clearing_r;
  iqh_pkg::bin_addr_t clr_addr_r;

  // Stage-one copy of the request whose read is in flight.
  logic               s1_chan_r;
  iqh_pkg::bin_addr_t s1_addr_r;
  logic               s1_inc_r;

  // Last write, for forwarding into a read issued at the same edge.
  logic               fw_valid_r;
  logic               fw_chan_r;
  iqh_pkg::bin_addr_t fw_addr_r;
  iqh_pkg::count_t    fw_data_r;

  iqh_pkg::count_t    even_rdata;
  iqh_pkg::count_t    odd_rdata;
  iqh_pkg::count_t    ram_rdata;
  iqh_pkg::count_t    new_count;
  logic               do_write;
  logic               fw_hit;
  logic               even_we;
  logic               odd_we;
  iqh_pkg::bin_addr_t waddr;
  iqh_pkg::count_t    wdata;

  // Step through every bin once after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + iqh_pkg::bin_addr_t'(1);
      if (clr_addr_r == iqh_pkg::BIN_LAST) begin
        clearing_r <= 1'b0;
      end
    end
  end

  assign busy = clearing_r;

  // Capture the request that goes with the read just issued.
  always_ff @(posedge clk) begin
    if (req.issue) begin
      s1_chan_r <= req.chan;
      s1_addr_r <= req.addr;
      s1_inc_r  <= req.inc;
    end
  end

  // Pick the bin value, taking the last write when it hit the same bin.
  always_comb begin
    ram_rdata = (s1_chan_r == iqh_pkg::CH_ODD) ? odd_rdata : even_rdata;
    fw_hit    = fw_valid_r && (fw_chan_r == s1_chan_r) && (fw_addr_r == s1_addr_r);
    cur_count = fw_hit ? fw_data_r : ram_rdata;
    new_count = iqh_pkg::sat_inc(cur_count);
    do_write  = adv && s1_inc_r;
  end

  // Write mux: clearing sweep or bin update.
  always_comb begin
    waddr   = clearing_r ? clr_addr_r : s1_addr_r;
    wdata   = clearing_r ? '0 : new_count;
    even_we = clearing_r || (do_write && (s1_chan_r == iqh_pkg::CH_EVEN));
    odd_we  = clearing_r || (do_write && (s1_chan_r == iqh_pkg::CH_ODD));
  end

  // Record the last bin update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_valid_r <= 1'b0;
    end else if (do_write) begin
      fw_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      fw_chan_r <= s1_chan_r;
      fw_addr_r <= s1_addr_r;
      fw_data_r <= new_count;
    end
  end

  iqh_bin_ram #(
    .ADDR_BITS(iqh_pkg::SAMPLE_BITS),
    .DATA_BITS(iqh_pkg::COUNT_BITS)
  ) u_even_ram (
    .clk   (clk),
    .we    (even_we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (req.issue),
    .raddr (req.addr),
    .rdata (even_rdata)
  );

  iqh_bin_ram #(
    .ADDR_BITS(iqh_pkg::SAMPLE_BITS),
    .DATA_BITS(iqh_pkg::COUNT_BITS)
  ) u_odd_ram (
    .clk   (clk),
    .we    (odd_we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (req.issue),
    .raddr (req.addr),
    .rdata (odd_rdata)
  );

  // No item may read a bin while the sweep is still clearing.
  a_no_issue_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    req.issue |-> !clearing_r)
    else $error("bin request issued during clearing sweep");

  // A forwarded bin was incremented from zero at least once.
  a_fw_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    fw_valid_r |-> (fw_data_r != '0))
    else $error("forwarded bin count is zero");

  // The sweep ends only after the last bin.
  a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(clearing_r) |-> ($past(clr_addr_r) == iqh_pkg::BIN_LAST))
    else $error("clearing sweep ended early");

endmodule

// ===== rtl/core/iqh_track.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iqh_track
// Channel parity, running minimum and maximum per channel, and saturating
// histogram totals. Gives the state after the item being accepted.
// ----------------------------------------------------------------------------
module iqh_track (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  logic                  action,
  input  iqh_pkg::sample_t      sample,
  input  logic                  start_of_buffer,
  input  logic                  hist_en,
  output iqh_pkg::track_state_t state_nxt,
  output logic                  went_odd_nxt
);

  iqh_pkg::track_state_t state_r;
  logic                  next_is_odd_r;
  logic                  next_is_odd_nxt;

  // Assign the channel and fold the sample into its extremes and total.
  always_comb begin
    state_nxt       = state_r;
    went_odd_nxt    = iqh_pkg::CH_EVEN;
    next_is_odd_nxt = next_is_odd_r;
    if (action == iqh_pkg::ACT_SAMPLE) begin
      went_odd_nxt    = start_of_buffer ? iqh_pkg::CH_EVEN : next_is_odd_r;
      next_is_odd_nxt = ~went_odd_nxt;
      if (went_odd_nxt) begin
        if (sample < state_r.odd_low) begin
          state_nxt.odd_low = sample;
        end
        if (sample > state_r.odd_high) begin
          state_nxt.odd_high = sample;
        end
        if (hist_en) begin
          state_nxt.odd_total = iqh_pkg::sat_inc(state_r.odd_total);
        end
      end else begin
        if (sample < state_r.even_low) begin
          state_nxt.even_low = sample;
        end
        if (sample > state_r.even_high) begin
          state_nxt.even_high = sample;
        end
        if (hist_en) begin
          state_nxt.even_total = iqh_pkg::sat_inc(state_r.even_total);
        end
      end
    end
  end

  // Commit on each accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_is_odd_r       <= 1'b0;
      state_r.even_low    <= iqh_pkg::SAMPLE_MAXV;
      state_r.even_high   <= iqh_pkg::SAMPLE_MINV;
      state_r.odd_low     <= iqh_pkg::SAMPLE_MAXV;
      state_r.odd_high    <= iqh_pkg::SAMPLE_MINV;
      state_r.even_total  <= '0;
      state_r.odd_total   <= '0;
    end else if (accept) begin
      next_is_odd_r <= next_is_odd_nxt;
      state_r       <= state_nxt;
    end
  end

endmodule

// ===== rtl/core/iq_sample_range_histogram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iq_sample_range_histogram
// Interleaved two-channel sample range tracker with per-channel histograms.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle unless out_stall or the clearing
// sweep holds it; each result passes stage one (memory read), then the
// output register. Each item reads one bin of the even or odd histogram
// memory; with the histogram enabled, a sample item writes the incremented
// bin back as it leaves stage one, and the last write is forwarded so that
// back-to-back samples of the same value count correctly. After reset the
// block clears all 65536 bins of both memories together, one bin per cycle,
// and holds in_stall high meanwhile; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module iq_sample_range_histogram (
  input  logic               clk,
  input  logic               rst_n,
  // configuration
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  // input items
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_action,
  input  logic signed [15:0] in_sample_value,
  input  logic               in_start_of_buffer,
  input  logic signed [15:0] in_bin_value,
  input  logic               in_read_channel,
  // result items
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_even_minimum,
  output logic signed [15:0] out_even_maximum,
  output logic signed [15:0] out_odd_minimum,
  output logic signed [15:0] out_odd_maximum,
  output logic        [31:0] out_bin_count,
  output logic        [31:0] out_even_total,
  output logic        [31:0] out_odd_total,
  output logic               out_went_odd
);

  logic                  hist_en_r;
  logic                  accept;
  logic                  adv;
  logic                  busy;
  iqh_pkg::bin_req_t     req;
  iqh_pkg::count_t       cur_count;
  iqh_pkg::track_state_t state_nxt;
  logic                  went_odd_nxt;

  // Stage one: read in flight.
  logic                  s1_valid_r;
  iqh_pkg::track_state_t s1_state_r;
  logic                  s1_read_r;
  logic                  s1_odd_r;

  logic                  out_valid_r;

  // Hold the histogram enable register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_en_r <= 1'b0;
    end else if (cfg_wr_en) begin
      hist_en_r <= cfg_wr_data;
    end
  end

  // Handshake: stage one moves on unless the output holds a stalled item.
  always_comb begin
    adv      = s1_valid_r && !(out_valid_r && out_stall);
    in_stall = busy || (s1_valid_r && !adv);
    accept   = in_valid && !in_stall;
  end

  // Build the bin request of the accepted item.
  always_comb begin
    req.issue = accept;
    req.inc   = (in_action == iqh_pkg::ACT_SAMPLE) && hist_en_r;
    if (in_action == iqh_pkg::ACT_READ) begin
      req.chan = in_read_channel;
      req.addr = iqh_pkg::bin_index(in_bin_value);
    end else begin
      req.chan = went_odd_nxt;
      req.addr = iqh_pkg::bin_index(in_sample_value);
    end
  end

  iqh_track u_track (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .action          (in_action),
    .sample          (iqh_pkg::to_sample(in_sample_value)),
    .start_of_buffer (in_start_of_buffer),
    .hist_en         (hist_en_r),
    .state_nxt       (state_nxt),
    .went_odd_nxt    (went_odd_nxt)
  );

  iqh_bin_store u_bins (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .adv       (adv),
    .busy      (busy),
    .cur_count (cur_count)
  );

  // Advance stage one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_state_r <= state_nxt;
      s1_read_r  <= (in_action == iqh_pkg::ACT_READ);
      s1_odd_r   <= went_odd_nxt;
    end
  end

  // Output register: load on advance, drop when taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_even_minimum <= iqh_pkg::PORT_SAMPLE_W'(s1_state_r.even_low);
      out_even_maximum <= iqh_pkg::PORT_SAMPLE_W'(s1_state_r.even_high);
      out_odd_minimum  <= iqh_pkg::PORT_SAMPLE_W'(s1_state_r.odd_low);
      out_odd_maximum  <= iqh_pkg::PORT_SAMPLE_W'(s1_state_r.odd_high);
      out_even_total   <= iqh_pkg::PORT_COUNT_W'(s1_state_r.even_total);
      out_odd_total    <= iqh_pkg::PORT_COUNT_W'(s1_state_r.odd_total);
      out_bin_count    <= s1_read_r ? iqh_pkg::PORT_COUNT_W'(cur_count) : '0;
      out_went_odd     <= s1_odd_r;
    end
  end

  assign out_valid = out_valid_r;

  // A held stage one must block new items.
  a_hold_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !adv) |-> !accept)
    else $error("item accepted while stage one is held");

  // An odd-channel sample carries no bin count.
  a_odd_no_bin: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_went_odd) |-> (out_bin_count == '0))
    else $error("sample result carries a bin count");

  // A new result comes only from stage one.
  a_out_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("result without a stage-one item");

endmodule
